@@ sv/pidtaw_pkg.sv @@
// ----------------------------------------------------------------------------
// pidtaw_pkg
// Shared types and register indexes for the PID controller with windup clamp.
// ----------------------------------------------------------------------------
package pidtaw_pkg;

  localparam int DATA_W  = 32;
  localparam int LIMIT_W = 31;
  localparam int OPND_W  = 33;
  localparam int PROD_W  = 49;
  localparam int SUM_W   = 51;
  localparam int DRIVE_W = 16;
  localparam int INDEX_W = 3;

  localparam logic [INDEX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [INDEX_W-1:0] REG_INTEG_COEFF  = 3'd1;
  localparam logic [INDEX_W-1:0] REG_DERIV_COEFF  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_WINDUP_LIMIT = 3'd3;
  localparam logic [INDEX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_coeff;
    logic signed [DATA_W-1:0] deriv_coeff;
    logic [LIMIT_W-1:0]       windup_limit;
    logic [LIMIT_W-1:0]       output_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] d;
    logic signed [PROD_W-1:0] r;
    logic                     e_zero;
    logic                     e_neg;
  } prod_t;

endpackage

@@ sv/pidtaw_qmul.sv @@
// ----------------------------------------------------------------------------
// pidtaw_qmul
// Q16.16 signed multiply, full-width product truncated toward zero.
// ----------------------------------------------------------------------------
module pidtaw_qmul
  import pidtaw_pkg::*;
(
  input  logic signed [OPND_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [PROD_W-1:0] res
);

  logic [OPND_W-1:0]        a_mag;
  logic [DATA_W-1:0]        b_mag;
  logic [OPND_W+DATA_W-1:0] prod;
  logic [PROD_W-1:0]        shifted;
  logic                     neg;

  always_comb begin
    a_mag   = a[OPND_W-1] ? (~a + OPND_W'(1)) : a;
    b_mag   = b[DATA_W-1] ? (~b + DATA_W'(1)) : b;
    prod    = (OPND_W+DATA_W)'(a_mag) * (OPND_W+DATA_W)'(b_mag);
    shifted = prod[OPND_W+DATA_W-1:16];
    neg     = a[OPND_W-1] ^ b[DATA_W-1];
    res     = neg ? $signed(~shifted + PROD_W'(1)) : $signed(shifted);
  end

endmodule

@@ sv/pidtaw_update.sv @@
// ----------------------------------------------------------------------------
// pidtaw_update
// Sum, anti-windup select, output clamp, stored output and drive register.
// ----------------------------------------------------------------------------
module pidtaw_update
  import pidtaw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  prod_t                     terms,
  input  cfg_t                      cfg,
  output logic signed [DRIVE_W-1:0] drive
);

  logic signed [DATA_W-1:0]  prev_output;
  logic signed [DATA_W-1:0]  prev_output_next;
  logic signed [DRIVE_W-1:0] drive_next;
  logic signed [SUM_W-1:0]   pd;
  logic signed [SUM_W-1:0]   r_term;
  logic signed [SUM_W-1:0]   y_sum;
  logic signed [SUM_W-1:0]   y_sel;
  logic signed [SUM_W-1:0]   y_clamp;
  logic signed [SUM_W-1:0]   wl;
  logic signed [SUM_W-1:0]   ol;
  logic                      over;
  logic                      same;
  logic [DATA_W-1:0]         y_mag;
  logic [DRIVE_W-1:0]        m;

  always_comb begin
    wl     = $signed(SUM_W'(cfg.windup_limit));
    ol     = $signed(SUM_W'(cfg.output_limit));
    pd     = SUM_W'(terms.p) + SUM_W'(terms.d);
    r_term = (cfg.integ_coeff == '0) ? '0 : (SUM_W'(terms.r) + SUM_W'(prev_output));
    y_sum  = pd + r_term;
    over   = (y_sum > wl) || (y_sum < -wl);
    same   = terms.e_zero || (y_sum == '0) || (terms.e_neg == y_sum[SUM_W-1]);
    y_sel  = (over && same) ? pd : y_sum;
    priority if (y_sel > ol) begin
      y_clamp = ol;
    end else if (y_sel < -ol) begin
      y_clamp = -ol;
    end else begin
      y_clamp = y_sel;
    end
    prev_output_next = y_clamp[DATA_W-1:0];
    y_mag = prev_output_next[DATA_W-1] ? (~prev_output_next + DATA_W'(1))
                                       : prev_output_next;
    m = {1'b0, y_mag[30:16]};
    drive_next = prev_output_next[DATA_W-1] ? $signed(~m + DRIVE_W'(1)) : $signed(m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_output <= '0;
    end else if (load) begin
      prev_output <= prev_output_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive <= drive_next;
    end
  end

endmodule

@@ sv/pid_trapezoid_antiwindup_unit.sv @@
// ----------------------------------------------------------------------------
// pid_trapezoid_antiwindup_unit
// Registers: input, product, output. Throughput: one request per cycle while
// out_stall is low; the loop on the stored output closes inside the final add
// and clamp stage, so nothing else limits the rate.
// Reset clears coefficients, limits, stored error and output, and all valids.
// ----------------------------------------------------------------------------
module pid_trapezoid_antiwindup_unit
  import pidtaw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [INDEX_W-1:0]        wr_index,
  input  logic [DATA_W-1:0]         wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [DATA_W-1:0]  err_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DRIVE_W-1:0] drive
);

  cfg_t                     cfg;
  logic                     s0_valid;
  logic signed [DATA_W-1:0] s0_err;
  logic                     s1_valid;
  prod_t                    s1_terms;
  prod_t                    terms_next;
  logic signed [DATA_W-1:0] prev_error;
  logic signed [OPND_W-1:0] e_ext;
  logic signed [OPND_W-1:0] e_diff;
  logic signed [OPND_W-1:0] e_sum;
  logic                     adv0;
  logic                     adv1;
  logic                     adv2;
  logic [DRIVE_W-1:0]       drive_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PROP_GAIN:    cfg.prop_gain    <= $signed(wr_data);
        REG_INTEG_COEFF:  cfg.integ_coeff  <= $signed(wr_data);
        REG_DERIV_COEFF:  cfg.deriv_coeff  <= $signed(wr_data);
        REG_WINDUP_LIMIT: cfg.windup_limit <= wr_data[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT: cfg.output_limit <= wr_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv2     = !out_valid || !out_stall;
  assign adv1     = !s1_valid || adv2;
  assign adv0     = !s0_valid || adv1;
  assign in_stall = !adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv0) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && in_valid) begin
      s0_err <= err_sample;
    end
  end

  assign e_ext  = OPND_W'(s0_err);
  assign e_diff = e_ext - OPND_W'(prev_error);
  assign e_sum  = e_ext + OPND_W'(prev_error);

  pidtaw_qmul u_mul_p (.a(e_ext),  .b(cfg.prop_gain),   .res(terms_next.p));
  pidtaw_qmul u_mul_d (.a(e_diff), .b(cfg.deriv_coeff), .res(terms_next.d));
  pidtaw_qmul u_mul_r (.a(e_sum),  .b(cfg.integ_coeff), .res(terms_next.r));

  assign terms_next.e_zero = (s0_err == '0);
  assign terms_next.e_neg  = s0_err[DATA_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      prev_error <= '0;
    end else if (adv1) begin
      s1_valid <= s0_valid;
      if (s0_valid) begin
        prev_error <= s0_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && s0_valid) begin
      s1_terms <= terms_next;
    end
  end

  pidtaw_update u_update (
    .clk   (clk),
    .rst   (rst),
    .load  (adv2 && s1_valid),
    .terms (s1_terms),
    .cfg   (cfg),
    .drive (drive)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2) begin
      out_valid <= s1_valid;
    end
  end

  assign drive_mag = drive[DRIVE_W-1] ? (~drive + DRIVE_W'(1)) : drive;

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s0_valid && s1_valid && out_valid))
    else $error("input stalled while pipeline has a free stage");

  a_drive_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_mag <= {1'b0, cfg.output_limit[30:16]}))
    else $error("drive exceeds output limit");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv2) |=> out_valid)
    else $error("product stage advanced without producing a result");

endmodule
